/* sv/first_fit_free_list_allocator_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit free-list allocator
// Concurrent assertion wrappers that can be compiled out as a group.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge while reset is released.
`define FFA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define FFA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FFA_ASSERT(label, prop, msg)
`define FFA_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* sv/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants, types and helper functions of the allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int ALIGN_BYTES     = 8;
    localparam int HEADER_BYTES    = 16;
    localparam int MAX_FREE_BLOCKS = 32;
    localparam int MAX_LIVE_ALLOCS = 32;
    localparam int ADDR_BITS       = 16;

    localparam int FIDX_BITS = $clog2(MAX_FREE_BLOCKS);
    localparam int RIDX_BITS = $clog2(MAX_LIVE_ALLOCS);
    localparam int CNT_BITS  = FIDX_BITS + 1;
    localparam int RCNT_BITS = RIDX_BITS + 1;
    localparam int LEN_BITS  = ADDR_BITS + 1;
    localparam int NEED_BITS = ADDR_BITS + 2;
    localparam int PAD_BITS  = 8;

    localparam logic [LEN_BITS-1:0] HEAP_MAX   = LEN_BITS'(1) << ADDR_BITS;
    localparam logic [LEN_BITS-1:0] HEAP_RESET = 17'd65536;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [2:0] {
        FW_FORMAT,
        FW_SPLIT,
        FW_SHIFT,
        FW_MERGE_BOTH,
        FW_MERGE_PREV,
        FW_MERGE_NEXT,
        FW_INSERT
    } t_fw_sel;

    typedef struct packed {
        logic                 latch;
        logic                 cfg_we;
        logic                 clr_all;
        logic                 free_rd;
        logic [FIDX_BITS-1:0] free_rd_idx;
        logic                 free_wr;
        logic [FIDX_BITS-1:0] free_wr_idx;
        t_fw_sel              free_wr_sel;
        logic                 rec_rd;
        logic [RIDX_BITS-1:0] rec_rd_idx;
        logic                 alloc_commit;
        logic                 cap_rec;
        logic                 cap_prev;
        logic                 release_rec;
    } t_dp_cmd;

    typedef struct packed {
        logic fit;
        logic rest_zero;
        logic slot_found;
        logic rec_match;
        logic gt;
        logic mprev_raw;
        logic mnext_raw;
    } t_dp_stat;

    // Padding in front of a block at start s: aligns the data offset and
    // leaves room for the header.
    function automatic logic [PAD_BITS-1:0] pad_for(input logic [ADDR_BITS-1:0] s);
        int p;
        p = ALIGN_BYTES - int'(s % ALIGN_BYTES);
        if (p < HEADER_BYTES) begin
            p = p + ((HEADER_BYTES - p + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        end
        return PAD_BITS'(p);
    endfunction

endpackage

/* sv/ffa_dp.sv */
// ----------------------------------------------------------------------------
// ffa_dp
// Datapath: free-block table, allocation record table and their arithmetic.
// ----------------------------------------------------------------------------
module ffa_dp
    import ffa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [LEN_BITS-1:0]  i_cfg_heap_size,
    input  logic [ADDR_BITS-1:0] i_req_size,
    input  logic [ADDR_BITS-1:0] i_free_addr,
    output t_dp_stat             o_stat,
    output logic [ADDR_BITS-1:0] o_data_addr
);

    logic [ADDR_BITS-1:0] free_start_mem [MAX_FREE_BLOCKS];
    logic [LEN_BITS-1:0]  free_len_mem   [MAX_FREE_BLOCKS];
    logic [ADDR_BITS-1:0] rec_daddr_mem  [MAX_LIVE_ALLOCS];
    logic [ADDR_BITS-1:0] rec_bstart_mem [MAX_LIVE_ALLOCS];
    logic [LEN_BITS-1:0]  rec_blen_mem   [MAX_LIVE_ALLOCS];

    logic [LEN_BITS-1:0]        r_heap;
    logic [ADDR_BITS-1:0]       r_req;
    logic [ADDR_BITS-1:0]       r_faddr;
    logic [ADDR_BITS-1:0]       r_addr;
    logic [ADDR_BITS-1:0]       r_rd_start;
    logic [LEN_BITS-1:0]        r_rd_len;
    logic [ADDR_BITS-1:0]       r_rec_daddr;
    logic [ADDR_BITS-1:0]       r_rec_bs;
    logic [LEN_BITS-1:0]        r_rec_bl;
    logic [RIDX_BITS-1:0]       r_rec_idx;
    logic [MAX_LIVE_ALLOCS-1:0] r_valid;
    logic [ADDR_BITS-1:0]       r_bs;
    logic [LEN_BITS-1:0]        r_bl;
    logic [RIDX_BITS-1:0]       r_slot;
    logic [ADDR_BITS-1:0]       r_prev_start;
    logic [LEN_BITS-1:0]        r_prev_len;

    logic [PAD_BITS-1:0]  pad;
    logic [NEED_BITS-1:0] need;
    logic [LEN_BITS-1:0]  rest;
    logic [RIDX_BITS-1:0] free_slot;
    logic                 slot_found;
    logic [ADDR_BITS-1:0] wr_start;
    logic [LEN_BITS-1:0]  wr_len;
    logic [NEED_BITS-1:0] prev_end;
    logic [NEED_BITS-1:0] blk_end;
    logic [ADDR_BITS-1:0] data_addr;

    assign pad       = pad_for(r_rd_start);
    assign need      = NEED_BITS'(r_req) + NEED_BITS'(pad);
    assign rest      = r_rd_len - need[LEN_BITS-1:0];
    assign data_addr = r_rd_start + ADDR_BITS'(pad);
    assign prev_end  = NEED_BITS'(r_prev_start) + NEED_BITS'(r_prev_len);
    assign blk_end   = NEED_BITS'(r_bs) + NEED_BITS'(r_bl);

    always_comb begin
        free_slot  = '0;
        slot_found = 1'b0;
        for (int k = MAX_LIVE_ALLOCS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_slot  = RIDX_BITS'(k);
                slot_found = 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.fit        = NEED_BITS'(r_rd_len) >= need;
        o_stat.rest_zero  = rest == '0;
        o_stat.slot_found = slot_found;
        o_stat.rec_match  = r_valid[r_rec_idx] && (r_rec_daddr == r_faddr);
        o_stat.gt         = r_rd_start > r_bs;
        o_stat.mprev_raw  = prev_end == NEED_BITS'(r_bs);
        o_stat.mnext_raw  = blk_end == NEED_BITS'(r_rd_start);
    end

    always_comb begin
        case (i_cmd.free_wr_sel)
            FW_FORMAT: begin
                wr_start = '0;
                wr_len   = r_heap;
            end
            FW_SPLIT: begin
                wr_start = r_rd_start + need[ADDR_BITS-1:0];
                wr_len   = rest;
            end
            FW_SHIFT: begin
                wr_start = r_rd_start;
                wr_len   = r_rd_len;
            end
            FW_MERGE_BOTH: begin
                wr_start = r_prev_start;
                wr_len   = r_prev_len + r_bl + r_rd_len;
            end
            FW_MERGE_PREV: begin
                wr_start = r_prev_start;
                wr_len   = r_prev_len + r_bl;
            end
            FW_MERGE_NEXT: begin
                wr_start = r_bs;
                wr_len   = r_bl + r_rd_len;
            end
            FW_INSERT: begin
                wr_start = r_bs;
                wr_len   = r_bl;
            end
            default: begin
                wr_start = r_bs;
                wr_len   = r_bl;
            end
        endcase
    end

    // Free table memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.free_wr) begin
            free_start_mem[i_cmd.free_wr_idx] <= wr_start;
            free_len_mem[i_cmd.free_wr_idx]   <= wr_len;
        end
        if (i_cmd.free_rd) begin
            r_rd_start <= free_start_mem[i_cmd.free_rd_idx];
            r_rd_len   <= free_len_mem[i_cmd.free_rd_idx];
        end
    end

    // Record table memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_commit) begin
            rec_daddr_mem[free_slot]  <= data_addr;
            rec_bstart_mem[free_slot] <= r_rd_start;
            rec_blen_mem[free_slot]   <= need[LEN_BITS-1:0];
        end
        if (i_cmd.rec_rd) begin
            r_rec_daddr <= rec_daddr_mem[i_cmd.rec_rd_idx];
            r_rec_bs    <= rec_bstart_mem[i_cmd.rec_rd_idx];
            r_rec_bl    <= rec_blen_mem[i_cmd.rec_rd_idx];
            r_rec_idx   <= i_cmd.rec_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap  <= HEAP_RESET;
            r_valid <= '0;
            r_addr  <= '0;
        end else begin
            if (i_cmd.cfg_we) begin
                r_heap <= (i_cfg_heap_size > HEAP_MAX) ? HEAP_MAX : i_cfg_heap_size;
            end
            if (i_cmd.clr_all) begin
                r_valid <= '0;
            end else if (i_cmd.alloc_commit) begin
                r_valid[free_slot] <= 1'b1;
            end else if (i_cmd.release_rec) begin
                r_valid[r_slot] <= 1'b0;
            end
            if (i_cmd.latch) begin
                r_addr <= '0;
            end else if (i_cmd.alloc_commit) begin
                r_addr <= data_addr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req   <= i_req_size;
            r_faddr <= i_free_addr;
        end
        if (i_cmd.cap_rec) begin
            r_bs   <= r_rec_bs;
            r_bl   <= r_rec_bl;
            r_slot <= r_rec_idx;
        end
        if (i_cmd.cap_prev) begin
            r_prev_start <= r_rd_start;
            r_prev_len   <= r_rd_len;
        end
    end

    assign o_data_addr = r_addr;

endmodule

/* sv/ffa_ctrl.sv */
// ----------------------------------------------------------------------------
// ffa_ctrl
// Controller: sequences table scans, shifts and the result strobe.
// ----------------------------------------------------------------------------
module ffa_ctrl
    import ffa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_func,
    input  logic       i_cfg_valid,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_cfg_ready,
    output logic       o_valid,
    output logic [1:0] o_status
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_RD,
        S_A_CMP,
        S_SD_RD,
        S_SD_WR,
        S_F_RD,
        S_F_CMP,
        S_P_RD,
        S_P_CMP,
        S_MERGE,
        S_SU_RD,
        S_SU_WR
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_BITS-1:0]  r_i, n_i;
    logic [CNT_BITS-1:0]  r_j, n_j;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic [CNT_BITS-1:0]  r_pos, n_pos;
    logic [RCNT_BITS-1:0] r_r, n_r;
    logic                 r_have_next, n_have_next;
    logic                 r_valid, n_valid;
    logic [1:0]           r_status, n_status;
    logic                 mprev;
    logic                 mnext;
    logic [CNT_BITS-1:0]  pos_m1;
    logic [CNT_BITS-1:0]  j_p1;
    logic [CNT_BITS-1:0]  j_m1;

    assign pos_m1 = r_pos - CNT_BITS'(1);
    assign j_p1   = r_j + CNT_BITS'(1);
    assign j_m1   = r_j - CNT_BITS'(1);
    assign mprev  = (r_pos != '0) && i_stat.mprev_raw;
    assign mnext  = r_have_next && i_stat.mnext_raw;

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_r         = r_r;
        n_have_next = r_have_next;
        n_valid     = 1'b0;
        n_status    = r_status;
        o_cmd       = '0;
        o_cmd.free_wr_sel = FW_SHIFT;

        case (r_state)
            S_INIT: begin
                o_cmd.free_wr     = 1'b1;
                o_cmd.free_wr_idx = '0;
                o_cmd.free_wr_sel = FW_FORMAT;
                o_cmd.clr_all     = 1'b1;
                n_cnt             = CNT_BITS'(1);
                n_state           = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_i         = '0;
                    n_r         = '0;
                    n_state     = (i_func == FUNC_ALLOC) ? S_A_RD : S_F_RD;
                end else if (i_cfg_valid) begin
                    o_cmd.cfg_we = 1'b1;
                    n_state      = S_INIT;
                end
            end
            S_A_RD: begin
                if (r_i == r_cnt) begin
                    n_status = ST_NO_FIT;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    o_cmd.free_rd     = 1'b1;
                    o_cmd.free_rd_idx = r_i[FIDX_BITS-1:0];
                    n_state           = S_A_CMP;
                end
            end
            S_A_CMP: begin
                if (!i_stat.fit) begin
                    n_i     = r_i + CNT_BITS'(1);
                    n_state = S_A_RD;
                end else if (!i_stat.slot_found) begin
                    n_status = ST_FULL;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    o_cmd.alloc_commit = 1'b1;
                    n_status           = ST_OK;
                    if (i_stat.rest_zero) begin
                        n_j     = r_i;
                        n_state = S_SD_RD;
                    end else begin
                        o_cmd.free_wr     = 1'b1;
                        o_cmd.free_wr_idx = r_i[FIDX_BITS-1:0];
                        o_cmd.free_wr_sel = FW_SPLIT;
                        n_valid           = 1'b1;
                        n_state           = S_IDLE;
                    end
                end
            end
            S_SD_RD: begin
                if (j_p1 >= r_cnt) begin
                    n_cnt   = r_cnt - CNT_BITS'(1);
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.free_rd     = 1'b1;
                    o_cmd.free_rd_idx = j_p1[FIDX_BITS-1:0];
                    n_state           = S_SD_WR;
                end
            end
            S_SD_WR: begin
                o_cmd.free_wr     = 1'b1;
                o_cmd.free_wr_idx = r_j[FIDX_BITS-1:0];
                o_cmd.free_wr_sel = FW_SHIFT;
                n_j               = j_p1;
                n_state           = S_SD_RD;
            end
            S_F_RD: begin
                if (r_r == RCNT_BITS'(MAX_LIVE_ALLOCS)) begin
                    n_status = ST_UNKNOWN;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    o_cmd.rec_rd     = 1'b1;
                    o_cmd.rec_rd_idx = r_r[RIDX_BITS-1:0];
                    n_state          = S_F_CMP;
                end
            end
            S_F_CMP: begin
                if (i_stat.rec_match) begin
                    o_cmd.cap_rec = 1'b1;
                    n_i           = '0;
                    n_state       = S_P_RD;
                end else begin
                    n_r     = r_r + RCNT_BITS'(1);
                    n_state = S_F_RD;
                end
            end
            S_P_RD: begin
                if (r_i == r_cnt) begin
                    n_pos       = r_cnt;
                    n_have_next = 1'b0;
                    n_state     = S_MERGE;
                end else begin
                    o_cmd.free_rd     = 1'b1;
                    o_cmd.free_rd_idx = r_i[FIDX_BITS-1:0];
                    n_state           = S_P_CMP;
                end
            end
            S_P_CMP: begin
                if (i_stat.gt) begin
                    n_pos       = r_i;
                    n_have_next = 1'b1;
                    n_state     = S_MERGE;
                end else begin
                    o_cmd.cap_prev = 1'b1;
                    n_i            = r_i + CNT_BITS'(1);
                    n_state        = S_P_RD;
                end
            end
            S_MERGE: begin
                n_status = ST_OK;
                if (mprev && mnext) begin
                    o_cmd.free_wr     = 1'b1;
                    o_cmd.free_wr_idx = pos_m1[FIDX_BITS-1:0];
                    o_cmd.free_wr_sel = FW_MERGE_BOTH;
                    o_cmd.release_rec = 1'b1;
                    n_j               = r_pos;
                    n_state           = S_SD_RD;
                end else if (mprev) begin
                    o_cmd.free_wr     = 1'b1;
                    o_cmd.free_wr_idx = pos_m1[FIDX_BITS-1:0];
                    o_cmd.free_wr_sel = FW_MERGE_PREV;
                    o_cmd.release_rec = 1'b1;
                    n_valid           = 1'b1;
                    n_state           = S_IDLE;
                end else if (mnext) begin
                    o_cmd.free_wr     = 1'b1;
                    o_cmd.free_wr_idx = r_pos[FIDX_BITS-1:0];
                    o_cmd.free_wr_sel = FW_MERGE_NEXT;
                    o_cmd.release_rec = 1'b1;
                    n_valid           = 1'b1;
                    n_state           = S_IDLE;
                end else if (r_cnt >= CNT_BITS'(MAX_FREE_BLOCKS)) begin
                    n_status = ST_FULL;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_j     = r_cnt;
                    n_state = S_SU_RD;
                end
            end
            S_SU_RD: begin
                if (r_j == r_pos) begin
                    o_cmd.free_wr     = 1'b1;
                    o_cmd.free_wr_idx = r_pos[FIDX_BITS-1:0];
                    o_cmd.free_wr_sel = FW_INSERT;
                    o_cmd.release_rec = 1'b1;
                    n_cnt             = r_cnt + CNT_BITS'(1);
                    n_valid           = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.free_rd     = 1'b1;
                    o_cmd.free_rd_idx = j_m1[FIDX_BITS-1:0];
                    n_state           = S_SU_WR;
                end
            end
            S_SU_WR: begin
                o_cmd.free_wr     = 1'b1;
                o_cmd.free_wr_idx = r_j[FIDX_BITS-1:0];
                o_cmd.free_wr_sel = FW_SHIFT;
                n_j               = j_m1;
                n_state           = S_SU_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_i         <= '0;
            r_j         <= '0;
            r_cnt       <= CNT_BITS'(1);
            r_pos       <= '0;
            r_r         <= '0;
            r_have_next <= 1'b0;
            r_valid     <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_cnt       <= n_cnt;
            r_pos       <= n_pos;
            r_r         <= n_r;
            r_have_next <= n_have_next;
            r_valid     <= n_valid;
            r_status    <= n_status;
        end
    end

    // A request offered in the same cycle as a heap write wins; the write
    // waits until the controller is idle again.
    assign o_busy      = r_state != S_IDLE;
    assign o_cfg_ready = (r_state == S_IDLE) && !i_start;
    assign o_valid     = r_valid;
    assign o_status    = r_status;

endmodule

/* sv/first_fit_free_list_allocator_top.sv */
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_top
// First-fit heap allocator with an address-ordered free table and coalescing.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result
// appears on o_status and o_data_addr for exactly one cycle while o_valid is
// high, and the receiver cannot stall it. How long a transaction takes
// depends on how far the controller walks the tables through their single
// read port, one entry at a time: an allocate scans the free blocks and
// shifts entries down when a block is used up, and a free scans the records
// and then the free blocks, and shifts entries when the block is inserted or
// two blocks merge. After reset, and after each heap size write, the S_INIT
// state rebuilds the free table as a single block; busy is high during it.
// A heap size write is taken only while busy is low and start is low, so a
// request offered in the same cycle goes first.
module first_fit_free_list_allocator_top
    import ffa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_func,
    input  logic [ADDR_BITS-1:0] i_req_size,
    input  logic [ADDR_BITS-1:0] i_free_addr,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic [ADDR_BITS-1:0] o_data_addr,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [LEN_BITS-1:0]  i_cfg_heap_size
);

`include "first_fit_free_list_allocator_top_assert.svh"

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // The controller owns counts, indexes and the result strobe.
    ffa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_func      (i_func),
        .i_cfg_valid (i_cfg_valid),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_cfg_ready (o_cfg_ready),
        .o_valid     (o_valid),
        .o_status    (o_status)
    );

    // The datapath owns both tables and the padding and merge arithmetic.
    ffa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_heap_size (i_cfg_heap_size),
        .i_req_size      (i_req_size),
        .i_free_addr     (i_free_addr),
        .o_stat          (stat),
        .o_data_addr     (o_data_addr)
    );

    // A result is only shown once the controller is back at rest.
    `FFA_ASSERT(a_result_idle, o_valid |-> !busy, "result strobe while busy")
    // An accepted transaction or heap write always makes the block busy.
    `FFA_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accept did not raise busy")
    // Failed requests and frees report a zero data offset.
    `FFA_ASSERT(a_fail_zero, (o_valid && o_status != ST_OK) |-> (o_data_addr == '0),
                "nonzero data offset on failure")
    // Heap writes are only offered to the user while idle.
    `FFA_ASSERT_ALWAYS(a_cfg_idle, o_cfg_ready |-> !busy, "config ready while busy")

endmodule

/* verif/first_fit_free_list_allocator_checker.sv */
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_checker
// Watches the request, result and heap size channels of the allocator. It
// keeps its own copy of the free table and the live records to predict every
// result, and it compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_checker
    import ffa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 i_func,
    input  logic [ADDR_BITS-1:0] i_req_size,
    input  logic [ADDR_BITS-1:0] i_free_addr,
    input  logic                 o_valid,
    input  logic [1:0]           o_status,
    input  logic [ADDR_BITS-1:0] o_data_addr,
    input  logic                 i_cfg_valid,
    input  logic                 o_cfg_ready,
    input  logic [LEN_BITS-1:0]  i_cfg_heap_size,
    output int                   o_pending,
    output int                   o_errors
);

    typedef struct packed {
        logic [1:0]           status;
        logic [ADDR_BITS-1:0] data_addr;
    } t_heap_reply;

    localparam longint ADDR_SPAN = longint'(1) << ADDR_BITS;

    logic [LEN_BITS-1:0]  heap_bytes;
    logic [ADDR_BITS-1:0] hole_base [MAX_FREE_BLOCKS];
    logic [LEN_BITS-1:0]  hole_len  [MAX_FREE_BLOCKS];
    int                   hole_count;
    bit                   owner_live [MAX_LIVE_ALLOCS];
    logic [ADDR_BITS-1:0] owner_data [MAX_LIVE_ALLOCS];
    logic [ADDR_BITS-1:0] owner_base [MAX_LIVE_ALLOCS];
    logic [LEN_BITS-1:0]  owner_len  [MAX_LIVE_ALLOCS];
    t_heap_reply          replies_due [$];
    int                   mismatches;

    function automatic void reformat_heap();
        for (int i = 0; i < MAX_FREE_BLOCKS; i++) begin
            hole_base[i] = '0;
            hole_len[i]  = '0;
        end
        hole_len[0] = (heap_bytes > HEAP_MAX) ? HEAP_MAX : heap_bytes;
        hole_count  = 1;
        for (int i = 0; i < MAX_LIVE_ALLOCS; i++) owner_live[i] = 1'b0;
    endfunction

    function automatic longint header_pad(longint s);
        longint p;
        p = ALIGN_BYTES - (s % ALIGN_BYTES);
        if (p < HEADER_BYTES)
            p += ((HEADER_BYTES - p + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        return p;
    endfunction

    function automatic t_heap_reply carve_block(longint req);
        t_heap_reply r;
        int     hit, slot;
        longint need, s, rest;
        r    = '{status: ST_NO_FIT, data_addr: '0};
        hit  = -1;
        slot = -1;
        need = 0;
        for (int i = 0; i < hole_count; i++) begin
            need = req + header_pad(longint'(hole_base[i]));
            if (longint'(hole_len[i]) >= need) begin
                hit = i;
                break;
            end
        end
        if (hit < 0) return r;
        for (int k = 0; k < MAX_LIVE_ALLOCS; k++)
            if (!owner_live[k]) begin
                slot = k;
                break;
            end
        if (slot < 0) begin
            r.status = ST_FULL;
            return r;
        end
        s    = longint'(hole_base[hit]);
        rest = longint'(hole_len[hit]) - need;
        if (rest > 0) begin
            hole_base[hit] = ADDR_BITS'((s + need) % ADDR_SPAN);
            hole_len[hit]  = LEN_BITS'(rest);
        end else begin
            for (int i = hit; i + 1 < hole_count; i++) begin
                hole_base[i] = hole_base[i+1];
                hole_len[i]  = hole_len[i+1];
            end
            hole_count--;
        end
        r.status           = ST_OK;
        r.data_addr        = ADDR_BITS'((s + header_pad(s)) % ADDR_SPAN);
        owner_live[slot]   = 1'b1;
        owner_data[slot]   = r.data_addr;
        owner_base[slot]   = ADDR_BITS'(s);
        owner_len[slot]    = LEN_BITS'(need);
        return r;
    endfunction

    function automatic t_heap_reply return_block(logic [ADDR_BITS-1:0] faddr);
        t_heap_reply r;
        int     slot, pos;
        longint bs, bl;
        bit     join_prev, join_next;
        r    = '{status: ST_UNKNOWN, data_addr: '0};
        slot = -1;
        for (int k = 0; k < MAX_LIVE_ALLOCS; k++)
            if (owner_live[k] && owner_data[k] == faddr) begin
                slot = k;
                break;
            end
        if (slot < 0) return r;
        bs  = longint'(owner_base[slot]);
        bl  = longint'(owner_len[slot]);
        pos = hole_count;
        for (int i = 0; i < hole_count; i++)
            if (longint'(hole_base[i]) > bs) begin
                pos = i;
                break;
            end
        join_next = pos < hole_count && bs + bl == longint'(hole_base[pos]);
        join_prev = pos > 0 &&
                    longint'(hole_base[pos-1]) + longint'(hole_len[pos-1]) == bs;
        if (join_prev && join_next) begin
            hole_len[pos-1] = LEN_BITS'(longint'(hole_len[pos-1]) + bl +
                                        longint'(hole_len[pos]));
            for (int i = pos; i + 1 < hole_count; i++) begin
                hole_base[i] = hole_base[i+1];
                hole_len[i]  = hole_len[i+1];
            end
            hole_count--;
        end else if (join_prev) begin
            hole_len[pos-1] = LEN_BITS'(longint'(hole_len[pos-1]) + bl);
        end else if (join_next) begin
            hole_base[pos] = ADDR_BITS'(bs);
            hole_len[pos]  = LEN_BITS'(bl + longint'(hole_len[pos]));
        end else begin
            if (hole_count >= MAX_FREE_BLOCKS) begin
                r.status = ST_FULL;
                return r;
            end
            for (int i = hole_count; i > pos; i--) begin
                hole_base[i] = hole_base[i-1];
                hole_len[i]  = hole_len[i-1];
            end
            hole_base[pos] = ADDR_BITS'(bs);
            hole_len[pos]  = LEN_BITS'(bl);
            hole_count++;
        end
        owner_live[slot] = 1'b0;
        r.status = ST_OK;
        return r;
    endfunction

    // Results are compared before a new request is predicted, so a result
    // and an acceptance at the same edge are handled in the right order.
    always @(posedge i_clk) begin
        t_heap_reply want;
        if (!i_rst_n) begin
            heap_bytes = HEAP_RESET;
            reformat_heap();
            replies_due.delete();
            mismatches = 0;
        end else begin
            if (o_valid) begin
                if (replies_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d data_addr %0d",
                                 o_status, o_data_addr);
                end else begin
                    want = replies_due.pop_front();
                    if (o_status !== want.status || o_data_addr !== want.data_addr) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: status exp %0d got %0d, data_addr exp %0d got %0d",
                                     want.status, o_status, want.data_addr, o_data_addr);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                heap_bytes = i_cfg_heap_size;
                reformat_heap();
            end
            if (start && !busy) begin
                if (i_func == FUNC_ALLOC) replies_due.push_back(carve_block(longint'(i_req_size)));
                else                      replies_due.push_back(return_block(i_free_addr));
            end
        end
        o_pending <= replies_due.size();
        o_errors  <= mismatches;
    end

endmodule

/* verif/first_fit_free_list_allocator_top_test.sv */
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_top_test
// Drives allocate and free transactions and heap size writes into the
// allocator; a checker beside it predicts and compares every result.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_top_test;
    import ffa_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_func = FUNC_ALLOC;
    logic [ADDR_BITS-1:0] i_req_size = '0;
    logic [ADDR_BITS-1:0] i_free_addr = '0;
    logic                 o_valid;
    logic [1:0]           o_status;
    logic [ADDR_BITS-1:0] o_data_addr;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [LEN_BITS-1:0]  i_cfg_heap_size = '0;
    int                   pending;
    int                   errors;
    int                   cycles = 0;
    int                   burst_left = 0;

    // Data offsets handed out by the block, used to build frees that hit.
    logic [ADDR_BITS-1:0] handed_out [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    first_fit_free_list_allocator_top dut (.*);

    first_fit_free_list_allocator_checker checker_i (
        .i_clk, .i_rst_n, .start, .busy, .i_func, .i_req_size, .i_free_addr,
        .o_valid, .o_status, .o_data_addr, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_heap_size, .o_pending(pending), .o_errors(errors)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("first_fit_free_list_allocator_test timeout");
            $display("first_fit_free_list_allocator_top_test failed");
            $finish;
        end
        if (o_valid && o_status == ST_OK && o_data_addr != '0)
            handed_out.push_back(o_data_addr);
    end

    // Sends one transaction. Busy only moves at rising edges, so seeing it
    // low at a falling edge means the next rising edge takes the request.
    // Start is dropped once each request is taken; between bursts a random gap is
    // inserted so that idle cycles land on every phase of the work.
    task automatic issue_request(logic func, logic [ADDR_BITS-1:0] req,
                                 logic [ADDR_BITS-1:0] faddr);
        if (burst_left == 0) begin
            start = 1'b0;
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 40)) @(negedge i_clk);
            burst_left = int'($urandom_range(1, 30));
        end
        while (busy) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start       = 1'b1;
        i_func      = func;
        i_req_size  = req;
        i_free_addr = faddr;
        @(negedge i_clk);
        burst_left--;
        if (burst_left == 0 || busy) start = 1'b0;
    endtask

    // Heap size writes happen only with nothing outstanding, and after a
    // pause long enough for the slowest transaction to finish.
    task automatic write_heap_size(logic [LEN_BITS-1:0] bytes);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (250) @(negedge i_clk);
        i_cfg_heap_size = bytes;
        i_cfg_valid     = 1'b1;
        while (!o_cfg_ready) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        handed_out.delete();
    endtask

    task automatic random_phase(int count, int size_cap);
        logic [ADDR_BITS-1:0] req;
        int pick;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 55) begin
                case ($urandom_range(0, 9))
                    0:       req = ADDR_BITS'($urandom);
                    1:       req = '0;
                    default: req = ADDR_BITS'($urandom_range(0, size_cap));
                endcase
                issue_request(FUNC_ALLOC, req, ADDR_BITS'($urandom));
            end else if (handed_out.size() != 0 && $urandom_range(0, 99) < 80) begin
                pick = int'($urandom_range(0, handed_out.size() - 1));
                req  = handed_out[pick];
                handed_out.delete(pick);
                issue_request(FUNC_FREE, ADDR_BITS'($urandom), req);
            end else begin
                issue_request(FUNC_FREE, ADDR_BITS'($urandom), ADDR_BITS'($urandom));
            end
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty request, oversize request, exact fit of the whole
        // heap and its release, unknown frees, and small odd sizes.
        issue_request(FUNC_ALLOC, 16'd0, 16'd0);
        issue_request(FUNC_ALLOC, 16'hFFFF, 16'd0);
        issue_request(FUNC_FREE, 16'd0, 16'd16);
        issue_request(FUNC_ALLOC, 16'd65496, 16'd0);
        issue_request(FUNC_ALLOC, 16'd1, 16'hFFFF);
        issue_request(FUNC_FREE, 16'hFFFF, 16'hFFFF);
        issue_request(FUNC_FREE, 16'd0, 16'd0);
        issue_request(FUNC_ALLOC, 16'd7, 16'd0);
        write_heap_size(17'd65536);
        issue_request(FUNC_ALLOC, 16'd65520, 16'd0);
        issue_request(FUNC_ALLOC, 16'd0, 16'd0);
        issue_request(FUNC_FREE, 16'd0, 16'd16);
        issue_request(FUNC_ALLOC, 16'd65504, 16'd0);
        issue_request(FUNC_ALLOC, 16'd0, 16'd0);
        write_heap_size(17'd64);
        issue_request(FUNC_ALLOC, 16'd48, 16'd0);
        issue_request(FUNC_ALLOC, 16'd0, 16'd0);
        issue_request(FUNC_FREE, 16'd0, 16'd16);

        // Random phases over several heap sizes: tiny heaps fill the tables
        // quickly, larger ones fragment into many free blocks.
        write_heap_size(17'd1000);
        random_phase(200, 40);
        write_heap_size(17'd64);
        random_phase(60, 40);
        write_heap_size(17'd131071);
        random_phase(200, 3000);
        write_heap_size(17'd0);
        random_phase(30, 64);
        write_heap_size(17'd600);
        random_phase(200, 24);
        write_heap_size(17'd65537);
        random_phase(150, 500);
        write_heap_size(17'd2048);
        random_phase(100, 100);

        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (errors == 0) $display("first_fit_free_list_allocator_top_test passed");
        else             $display("first_fit_free_list_allocator_top_test failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/ffa_pkg.sv
sv/ffa_dp.sv
sv/ffa_ctrl.sv
sv/first_fit_free_list_allocator_top.sv
verif/first_fit_free_list_allocator_checker.sv
verif/first_fit_free_list_allocator_top_test.sv
